// ----- rtl/b64dec_pkg.sv -----
// shared types and constants for the base64 stream decoder
// no dependencies
`default_nettype none

package b64dec_pkg;

    localparam int ByteW   = 8;
    localparam int SextetW = 6;
    localparam int PosW    = 2;

    localparam logic [ByteW-1:0] CHR_SPACE   = 8'h20;
    localparam logic [ByteW-1:0] CHR_NEWLINE = 8'h0A;
    localparam logic [ByteW-1:0] CHR_PAD     = 8'h3D;
    localparam logic [ByteW-1:0] CHR_PLUS    = 8'h2B;
    localparam logic [ByteW-1:0] CHR_SLASH   = 8'h2F;
    localparam logic [ByteW-1:0] CHR_UP_A    = 8'h41;
    localparam logic [ByteW-1:0] CHR_UP_Z    = 8'h5A;
    localparam logic [ByteW-1:0] CHR_LO_A    = 8'h61;
    localparam logic [ByteW-1:0] CHR_LO_Z    = 8'h7A;
    localparam logic [ByteW-1:0] CHR_DIG_0   = 8'h30;
    localparam logic [ByteW-1:0] CHR_DIG_9   = 8'h39;

    localparam logic [SextetW-1:0] SEXT_LO_OFS  = 6'd26;
    localparam logic [SextetW-1:0] SEXT_DIG_OFS = 6'd52;
    localparam logic [SextetW-1:0] SEXT_PLUS    = 6'd62;
    localparam logic [SextetW-1:0] SEXT_SLASH   = 6'd63;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef struct packed {
        logic [SextetW-1:0] sextet;
        logic               is_pad;
        logic               is_bad;
        logic               is_space;
    } char_class_t;

endpackage

`default_nettype wire

// ----- rtl/b64dec_classify.sv -----
// character classifier: maps one ascii character to a sextet or a class flag
// depends on b64dec_pkg
`default_nettype none

module b64dec_classify
    import b64dec_pkg::*;
(
    input  wire logic [ByteW-1:0] chr,
    output char_class_t           cls
);

    logic [ByteW-1:0] ofs;

    always_comb
    begin
        ofs          = '0;
        cls.sextet   = '0;
        cls.is_pad   = 1'b0;
        cls.is_bad   = 1'b0;
        cls.is_space = (chr == CHR_SPACE) || (chr == CHR_NEWLINE);
        priority if (chr >= CHR_UP_A && chr <= CHR_UP_Z)
        begin
            ofs        = chr - CHR_UP_A;
            cls.sextet = ofs[SextetW-1:0];
        end
        else if (chr >= CHR_LO_A && chr <= CHR_LO_Z)
        begin
            ofs        = chr - CHR_LO_A;
            cls.sextet = ofs[SextetW-1:0] + SEXT_LO_OFS;
        end
        else if (chr >= CHR_DIG_0 && chr <= CHR_DIG_9)
        begin
            ofs        = chr - CHR_DIG_0;
            cls.sextet = ofs[SextetW-1:0] + SEXT_DIG_OFS;
        end
        else if (chr == CHR_PLUS)
        begin
            cls.sextet = SEXT_PLUS;
        end
        else if (chr == CHR_SLASH)
        begin
            cls.sextet = SEXT_SLASH;
        end
        else if (chr == CHR_PAD)
        begin
            cls.is_pad = 1'b1;
        end
        else
        begin
            cls.is_bad = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/base64_stream_decoder_top.sv -----
// base64 stream decoder, top level
// depends on b64dec_pkg and b64dec_classify
//
// usage:
//   input channel: one character per beat on in_byte, or an end marker
//   (end_mark high, in_byte ignored) that drops a partial group and clears
//   the halt after an error. output channel: one beat per decoded byte
//   (kind = data) or for the first bad character in strict mode (kind = error,
//   out_byte zero) and halts. characters that produce nothing give no output
//   beat. configuration: cfg_data bit 0 sets skip_bad_characters; cfg_ready is
//   always high, write only while the decoder is idle.
//   a result passes from the input register to the result register.
//   throughput: one character per cycle while the output does not stall,
//   with group position and previous sextet updated once per character.
//   reset: group position, previous sextet, halt and the mode bit clear,
//   both pipeline registers empty.
//   a stall on the output holds the result register; the input register then
//   holds its beat and in_stall rises once it is occupied.
`default_nettype none

module base64_stream_decoder_top
    import b64dec_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_stall,
    input  wire logic [ByteW-1:0] in_byte,
    input  wire logic             end_mark,
    output      logic             out_valid,
    input  wire logic             out_stall,
    output      logic [ByteW-1:0] out_byte,
    output      logic             kind,
    input  wire logic             cfg_valid,
    output      logic             cfg_ready,
    input  wire logic             cfg_data
);

    logic               skip_reg;
    logic               s1_valid_reg;
    logic [ByteW-1:0]   s1_byte_reg;
    logic               s1_end_reg;
    logic [PosW-1:0]    pos_reg, pos_next;
    logic [SextetW-1:0] prev_reg, prev_next;
    logic               halted_reg, halted_next;
    logic               out_valid_reg;
    logic [ByteW-1:0]   out_byte_reg, out_byte_next;
    logic               kind_reg, kind_next;
    logic               res_valid;
    logic               out_free;
    logic               advance;
    char_class_t        cls;

    b64dec_classify u_classify (
        .chr (s1_byte_reg),
        .cls (cls)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign kind      = kind_reg;

    always_comb
    begin
        pos_next      = pos_reg;
        prev_next     = prev_reg;
        halted_next   = halted_reg;
        res_valid     = 1'b0;
        out_byte_next = '0;
        kind_next     = KIND_DATA;
        priority if (s1_end_reg)
        begin
            pos_next    = '0;
            halted_next = 1'b0;
        end
        else if (halted_reg)
        begin
        end
        else if (pos_reg == '0 && cls.is_space)
        begin
        end
        else if (cls.is_pad)
        begin
            pos_next = '0;
        end
        else if (cls.is_bad)
        begin
            pos_next = '0;
            if (!skip_reg)
            begin
                halted_next = 1'b1;
                res_valid   = 1'b1;
                kind_next   = KIND_ERROR;
            end
        end
        else
        begin
            prev_next = cls.sextet;
            pos_next  = pos_reg + 1'b1;
            unique case (pos_reg)
                2'd0:
                begin
                end
                2'd1:
                begin
                    res_valid     = 1'b1;
                    out_byte_next = {prev_reg, cls.sextet[5:4]};
                end
                2'd2:
                begin
                    res_valid     = 1'b1;
                    out_byte_next = {prev_reg[3:0], cls.sextet[5:2]};
                end
                default:
                begin
                    res_valid     = 1'b1;
                    out_byte_next = {prev_reg[1:0], cls.sextet};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            prev_reg      <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                skip_reg <= cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                pos_reg       <= pos_next;
                prev_reg      <= prev_next;
                halted_reg    <= halted_next;
                out_valid_reg <= res_valid;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= in_byte;
            s1_end_reg  <= end_mark;
        end
        if (advance)
        begin
            out_byte_reg <= out_byte_next;
            kind_reg     <= kind_next;
        end
    end

endmodule

`default_nettype wire
